// File: design/slbh_pkg.sv
// Shared types, codes and helpers for the sequenced link block handler.
// No dependencies; imported by slbh_fifo, the top level and the checker.
package slbh_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int RES_MAX = 4;

    typedef enum logic [2:0] {
        CMD_RX_BYTE  = 3'd0,
        CMD_START_I  = 3'd1,
        CMD_PAYLOAD  = 3'd2,
        CMD_PULL     = 3'd3,
        CMD_CLR_CNT  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_REJ  = 2'd1,
        PEND_I    = 2'd2,
        PEND_RETX = 2'd3
    } pend_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_TX      = 2'd2;

    localparam logic [2:0] VERD_OTHER   = 3'd0;
    localparam logic [2:0] VERD_I       = 3'd1;
    localparam logic [2:0] VERD_REJ     = 3'd2;
    localparam logic [2:0] VERD_RES     = 3'd3;
    localparam logic [2:0] VERD_INVALID = 3'd4;

    localparam logic       REG_OWN_ADDR = 1'b0;
    localparam logic       REG_REJ_DEST = 1'b1;

    localparam logic [7:0] I_MASK   = 8'h11;
    localparam logic [7:0] REJ_MASK = 8'h09;
    localparam logic [7:0] RES_CTRL = 8'hEF;

    // one result beat; the fields that tdata carries are in tdata order from the high bit down
    typedef struct packed {
        logic [2:0] send_count;
        logic [2:0] receive_count;
        logic [7:0] received_length;
        logic       checksum_ok;
        logic [2:0] verdict;
        logic [7:0] out_byte;
        logic       end_of_frame;
        logic [1:0] kind;
    } res_t;

    function automatic res_t mk_tx(input logic [7:0] b, input logic eof);
        res_t r;
        r = '0;
        r.kind = KIND_TX;
        r.out_byte = b;
        r.end_of_frame = eof;
        return r;
    endfunction

    function automatic res_t mk_payload(input logic [7:0] b);
        res_t r;
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.out_byte = b;
        return r;
    endfunction

endpackage

// File: design/sequenced_link_block_handler.sv
// Sequenced link block handler: one input beat per cycle, whose result beats are registered
// into an 8-entry queue; up to four result beats per input leave one per cycle from the queue.
// Input ready drops while fewer than four queue slots are free; the output handshake sets
// sustained rate. The retransmit store is a synchronous RAM read ahead at the next tx position.
// Reset (rst_n, async, low) clears counters, pointers, registers (rejdst_reg to 3); RAM, rd_data_reg stay undefined.
module sequenced_link_block_handler #(
    parameter int STORE_DEPTH = slbh_pkg::STORE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [slbh_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // data_byte, frame_length
    input  logic [2:0]                       s_axis_tuser,  // command
    input  logic                             s_axis_tlast,  // last_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [slbh_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // out_byte, verdict, checksum_ok,
                                                            // received_length, receive_count,
                                                            // send_count, zero pad
    output logic [1:0]                       m_axis_tuser,  // kind
    output logic                             m_axis_tlast,  // end_of_frame
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [3:0]                       cfg_data
);
    import slbh_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int MAX_PAYLOAD = (STORE_DEPTH - 4 < 251) ? STORE_DEPTH - 4 : 251;

    logic [7:0] mem [STORE_DEPTH];

    logic [3:0] own_reg, rejdst_reg;
    logic [7:0] rx_cs_reg, rx_cs_next, rx_pos_reg, rx_pos_next;
    logic [7:0] rx_addr_reg, rx_addr_next, rx_ctrl_reg, rx_ctrl_next, rx_len_reg, rx_len_next;
    logic [2:0] rseq_reg, rseq_next, sseq_reg, sseq_next;
    pend_t      pend_reg, pend_next;
    logic [7:0] retlen_reg, retlen_next, tx_pos_reg, tx_pos_next, tx_cs_reg, tx_cs_next;
    logic [7:0] hdr0_reg, hdr0_next, hdr1_reg, hdr1_next, hdr2_reg, hdr2_next;
    logic [7:0] trail_reg, trail_next;
    logic       done_reg, done_next;
    logic [7:0] rd_data_reg;

    logic          we;
    logic [7:0]    wdata;
    logic          accept;
    logic [2:0]    push_n;
    res_t          push_data [RES_MAX];
    res_t          out_res;
    logic          space_ok;

    logic [7:0] b, flen;
    cmd_t       cmd;

    assign b      = s_axis_tdata[7:0];
    assign flen   = s_axis_tdata[15:8];
    assign cmd    = cmd_t'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = space_ok;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [7:0] a, c, l, v, plen, stored;
        logic       ok, eof;
        logic [2:0] verd;
        logic [8:0] endpos;

        rx_cs_next = rx_cs_reg;     rx_pos_next = rx_pos_reg;
        rx_addr_next = rx_addr_reg; rx_ctrl_next = rx_ctrl_reg; rx_len_next = rx_len_reg;
        rseq_next = rseq_reg;       sseq_next = sseq_reg;       pend_next = pend_reg;
        retlen_next = retlen_reg;   tx_pos_next = tx_pos_reg;   tx_cs_next = tx_cs_reg;
        hdr0_next = hdr0_reg;       hdr1_next = hdr1_reg;       hdr2_next = hdr2_reg;
        trail_next = trail_reg;     done_next = done_reg;
        we = 1'b0; wdata = b;
        push_n = '0;
        for (int i = 0; i < RES_MAX; i++)
            push_data[i] = '0;
        a = '0; c = '0; l = '0; v = '0; plen = '0; stored = '0;
        ok = 1'b0; eof = 1'b0; verd = VERD_OTHER; endpos = '0;

        if (accept)
        begin
            case (cmd)
                CMD_RX_BYTE:
                begin
                    if (!s_axis_tlast)
                    begin
                        if (rx_pos_reg == 8'd0)
                        begin
                            rx_addr_next = b; rx_ctrl_next = '0; rx_len_next = '0;
                        end
                        else if (rx_pos_reg == 8'd1)
                            rx_ctrl_next = b;
                        else if (rx_pos_reg == 8'd2)
                            rx_len_next = b;
                        rx_cs_next = rx_cs_reg ^ b;
                        if (rx_pos_reg >= 8'd3)
                        begin
                            push_data[0] = mk_payload(b);
                            push_n = 3'd1;
                        end
                        if (rx_pos_reg != 8'hFF)
                            rx_pos_next = rx_pos_reg + 8'd1;
                    end
                    else
                    begin
                        // header bytes never received count as zero
                        a = (rx_pos_reg == 8'd0) ? 8'd0 : rx_addr_reg;
                        c = (rx_pos_reg <= 8'd1) ? 8'd0 : rx_ctrl_reg;
                        l = (rx_pos_reg <= 8'd2) ? 8'd0 : rx_len_reg;
                        rx_addr_next = a; rx_ctrl_next = c; rx_len_next = l;
                        ok = (rx_cs_reg == b);
                        if (a[3:0] == own_reg)
                        begin
                            if ((c & I_MASK) == 8'd0)
                            begin
                                verd = VERD_I;
                                rseq_next = rseq_reg + 3'd1;
                            end
                            else if ((c & REJ_MASK) == REJ_MASK)
                            begin
                                verd = VERD_REJ;
                                sseq_next = c[7:5];
                            end
                            else if (c == RES_CTRL)
                                verd = VERD_RES;
                            else
                            begin
                                verd = VERD_INVALID;
                                l = '0;
                            end
                            tx_pos_next = '0;
                            tx_cs_next = '0;
                            if (!ok || verd == VERD_INVALID)
                                pend_next = PEND_REJ;
                            else if (verd == VERD_I)
                                pend_next = PEND_I;
                            else if (verd == VERD_REJ)
                            begin
                                if (retlen_reg == 8'd0)
                                begin
                                    sseq_next = c[7:5] + 3'd1;
                                    pend_next = PEND_NONE;
                                end
                                else
                                    pend_next = PEND_RETX;
                            end
                            else
                                pend_next = PEND_NONE;
                        end
                        push_data[0].kind = KIND_VERDICT;
                        push_data[0].verdict = verd;
                        push_data[0].checksum_ok = ok;
                        push_data[0].received_length = l;
                        push_data[0].receive_count = rseq_next;
                        push_data[0].send_count = sseq_next;
                        push_n = 3'd1;
                        rx_cs_next = '0;
                        rx_pos_next = '0;
                    end
                end
                CMD_START_I:
                begin
                    if (pend_reg == PEND_I)
                    begin
                        plen = (flen > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : flen;
                        hdr0_next = {rx_addr_reg[3:0], rx_addr_reg[7:4]};
                        hdr1_next = {rseq_reg, 1'b0, sseq_reg, 1'b0};
                        hdr2_next = plen;
                        done_next = 1'b0;
                        tx_cs_next = hdr0_next ^ hdr1_next ^ plen;
                        push_data[0] = mk_tx(hdr0_next, 1'b0);
                        push_data[1] = mk_tx(hdr1_next, 1'b0);
                        push_data[2] = mk_tx(plen, 1'b0);
                        push_n = 3'd3;
                        tx_pos_next = 8'd3;
                        retlen_next = 8'd3;
                        if (plen == 8'd0)
                        begin
                            trail_next = tx_cs_next;
                            done_next = 1'b1;
                            push_data[3] = mk_tx(tx_cs_next, 1'b1);
                            push_n = 3'd4;
                            tx_pos_next = 8'd4;
                            retlen_next = 8'd4;
                            tx_cs_next = '0;
                            sseq_next = sseq_reg + 3'd1;
                            pend_next = PEND_NONE;
                        end
                    end
                end
                CMD_PAYLOAD:
                begin
                    if (pend_reg == PEND_I && tx_pos_reg >= 8'd3)
                    begin
                        we = 1'b1;
                        wdata = b;
                        tx_cs_next = tx_cs_reg ^ b;
                        tx_pos_next = tx_pos_reg + 8'd1;
                        retlen_next = tx_pos_next;
                        push_data[0] = mk_tx(b, 1'b0);
                        push_n = 3'd1;
                        endpos = {1'b0, hdr2_reg} + 9'd3;
                        if ({1'b0, tx_pos_next} >= endpos)
                        begin
                            // checksum trails in a register, keeps the RAM at one write
                            trail_next = tx_cs_next;
                            done_next = 1'b1;
                            push_data[1] = mk_tx(tx_cs_next, 1'b1);
                            push_n = 3'd2;
                            tx_pos_next = tx_pos_reg + 8'd2;
                            retlen_next = tx_pos_next;
                            tx_cs_next = '0;
                            sseq_next = sseq_reg + 3'd1;
                            pend_next = PEND_NONE;
                        end
                    end
                end
                CMD_PULL:
                begin
                    if (pend_reg == PEND_REJ)
                    begin
                        eof = 1'b0;
                        if (tx_pos_reg == 8'd0)
                            v = {own_reg, rejdst_reg};
                        else if (tx_pos_reg == 8'd1)
                            v = {sseq_reg, 5'(REJ_MASK)};
                        else if (tx_pos_reg == 8'd2)
                            v = '0;
                        else
                        begin
                            v = tx_cs_reg;
                            eof = 1'b1;
                        end
                        tx_cs_next = tx_cs_reg ^ v;
                        tx_pos_next = tx_pos_reg + 8'd1;
                        if (eof)
                            pend_next = PEND_NONE;
                        push_data[0] = mk_tx(v, eof);
                        push_n = 3'd1;
                    end
                    else if (pend_reg == PEND_RETX)
                    begin
                        if (tx_pos_reg == 8'd0)
                            stored = hdr0_reg;
                        else if (tx_pos_reg == 8'd1)
                            stored = hdr1_reg;
                        else if (tx_pos_reg == 8'd2)
                            stored = hdr2_reg;
                        else if (done_reg && tx_pos_reg == retlen_reg - 8'd1)
                            stored = trail_reg;
                        else
                            stored = rd_data_reg;
                        eof = ({1'b0, tx_pos_reg} + 9'd1 >= {1'b0, retlen_reg});
                        tx_pos_next = tx_pos_reg + 8'd1;
                        if (eof)
                        begin
                            sseq_next = sseq_reg + 3'd1;
                            pend_next = PEND_NONE;
                        end
                        push_data[0] = mk_tx(stored, eof);
                        push_n = 3'd1;
                    end
                end
                CMD_CLR_CNT:
                begin
                    rseq_next = '0;
                    sseq_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // read ahead at the next tx position; writes only happen while a reply is built,
    // never while a retransmission is pulled, so no bypass is needed
    always_ff @(posedge clk)
    begin
        if (we)
            mem[tx_pos_reg[AW-1:0]] <= wdata;
        rd_data_reg <= mem[tx_pos_next[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg <= '0;      rejdst_reg <= 4'd3;
            rx_cs_reg <= '0;    rx_pos_reg <= '0;
            rx_addr_reg <= '0;  rx_ctrl_reg <= '0;  rx_len_reg <= '0;
            rseq_reg <= '0;     sseq_reg <= '0;     pend_reg <= PEND_NONE;
            retlen_reg <= '0;   tx_pos_reg <= '0;   tx_cs_reg <= '0;
            hdr0_reg <= '0;     hdr1_reg <= '0;     hdr2_reg <= '0;
            trail_reg <= '0;    done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_OWN_ADDR)
                    own_reg <= cfg_data;
                else
                    rejdst_reg <= cfg_data;
            end
            rx_cs_reg <= rx_cs_next;    rx_pos_reg <= rx_pos_next;
            rx_addr_reg <= rx_addr_next; rx_ctrl_reg <= rx_ctrl_next; rx_len_reg <= rx_len_next;
            rseq_reg <= rseq_next;      sseq_reg <= sseq_next;      pend_reg <= pend_next;
            retlen_reg <= retlen_next;  tx_pos_reg <= tx_pos_next;  tx_cs_reg <= tx_cs_next;
            hdr0_reg <= hdr0_next;      hdr1_reg <= hdr1_next;      hdr2_reg <= hdr2_next;
            trail_reg <= trail_next;    done_reg <= done_next;
        end
    end

    slbh_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_data (push_data),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.end_of_frame;
    assign m_axis_tdata = {6'd0, out_res.send_count, out_res.receive_count,
                           out_res.received_length, out_res.checksum_ok,
                           out_res.verdict, out_res.out_byte};

endmodule

// File: design/slbh_fifo.sv
// Result queue: takes up to four result beats per cycle, hands out one.
// Depends on slbh_pkg for res_t.
module slbh_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         push_n,
    input  slbh_pkg::res_t     push_data [slbh_pkg::RES_MAX],
    output logic               space_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output slbh_pkg::res_t     out_data
);
    import slbh_pkg::*;

    localparam int DEPTH = 8;

    res_t       q_reg [DEPTH];
    logic [2:0] wr_reg;
    logic [2:0] rd_reg;
    logic [3:0] cnt_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 4'd0);
    assign out_data  = q_reg[rd_reg];
    assign space_ok  = (cnt_reg <= 4'(DEPTH - RES_MAX));

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (3'(i) < push_n)
                q_reg[wr_reg + 3'(i)] <= push_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + push_n;
            rd_reg  <= rd_reg + 3'(pop);
            cnt_reg <= cnt_reg + 4'(push_n) - 4'(pop);
        end
    end

endmodule

// File: design/slbh_checker.sv
// Port-level checks for the sequenced link block handler, bound to the top level.
// Depends on slbh_pkg for the result kind codes.
module slbh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import slbh_pkg::*;

    // hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_PAYLOAD || m_axis_tuser == KIND_VERDICT
                           || m_axis_tuser == KIND_TX))
        else $error("bad result kind");

    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_TX)
        else $error("frame end outside transmitted bytes");

    a_verd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_VERDICT |-> m_axis_tdata[7:0] == 8'd0)
        else $error("verdict beat carries a byte");

    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_VERDICT |-> m_axis_tdata[25:8] == 18'd0)
        else $error("byte beat carries verdict fields");

endmodule

bind sequenced_link_block_handler slbh_checker u_slbh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb_top.sv
// Self-checking bench for sequenced_link_block_handler: a scoreboard class predicts every
// result beat from the accepted command beats and checks the master stream against it.
// Depends on slbh_pkg and the design top level only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import slbh_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PAYLOAD = 251;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       eof;
        logic [2:0] verdict;
        logic       ok;
        logic [7:0] len;
        logic [2:0] rc;
        logic [2:0] sc;
    } link_beat_t;

    class link_scoreboard;
        logic [3:0] own_addr;
        logic [3:0] rej_dest;
        logic [7:0] rx_sum, rx_pos, rx_addr, rx_ctrl, rx_len;
        logic [2:0] rx_seq, tx_seq;
        pend_t      pend;
        logic [7:0] frame_mem [256];
        logic [7:0] frame_len, tx_pos, tx_sum;
        link_beat_t expected_q [$];
        int         errors;
        int         items;

        function new();
            own_addr = 4'd0;
            rej_dest = 4'd3;
            rx_sum = 0; rx_pos = 0; rx_addr = 0; rx_ctrl = 0; rx_len = 0;
            rx_seq = 0; tx_seq = 0;
            pend = PEND_NONE;
            frame_len = 0; tx_pos = 0; tx_sum = 0;
            errors = 0;
            items = 0;
        endfunction

        function void put(logic [1:0] k, logic [7:0] b, logic e, logic [2:0] v = 0,
                          logic o = 0, logic [7:0] l = 0, logic [2:0] r = 0,
                          logic [2:0] s = 0);
            link_beat_t x;
            x.kind = k; x.out_byte = b; x.eof = e; x.verdict = v;
            x.ok = o; x.len = l; x.rc = r; x.sc = s;
            expected_q.push_back(x);
        endfunction

        function void frame_put(logic [7:0] v, logic e);
            frame_mem[tx_pos] = v;
            tx_sum ^= v;
            tx_pos++;
            frame_len = tx_pos;
            put(KIND_TX, v, e);
        endfunction

        function void close_i();
            frame_put(tx_sum, 1'b1);
            tx_seq++;
            pend = PEND_NONE;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic       ok;
            logic [2:0] v;
            logic [7:0] l;
            if (!last) begin
                if (rx_pos == 0) begin
                    rx_addr = b; rx_ctrl = 0; rx_len = 0;
                end
                else if (rx_pos == 1)
                    rx_ctrl = b;
                else if (rx_pos == 2)
                    rx_len = b;
                rx_sum ^= b;
                if (rx_pos >= 3)
                    put(KIND_PAYLOAD, b, 1'b0);
                if (rx_pos != 8'hFF)
                    rx_pos++;
                return;
            end
            // header bytes never seen read as zero
            if (rx_pos == 0) begin
                rx_addr = 0; rx_ctrl = 0; rx_len = 0;
            end
            else if (rx_pos == 1) begin
                rx_ctrl = 0; rx_len = 0;
            end
            else if (rx_pos == 2)
                rx_len = 0;
            ok = (rx_sum == b);
            l = rx_len;
            if (rx_addr[3:0] != own_addr)
                v = VERD_OTHER;
            else begin
                if ((rx_ctrl & I_MASK) == 0) begin
                    v = VERD_I;
                    rx_seq++;
                end
                else if ((rx_ctrl & REJ_MASK) == REJ_MASK) begin
                    v = VERD_REJ;
                    tx_seq = rx_ctrl[7:5];
                end
                else if (rx_ctrl == RES_CTRL)
                    v = VERD_RES;
                else begin
                    v = VERD_INVALID;
                    l = 0;
                end
                tx_pos = 0;
                tx_sum = 0;
                if (!ok || v == VERD_INVALID)
                    pend = PEND_REJ;
                else if (v == VERD_I)
                    pend = PEND_I;
                else if (v == VERD_REJ) begin
                    if (frame_len == 0) begin
                        tx_seq++;
                        pend = PEND_NONE;
                    end
                    else
                        pend = PEND_RETX;
                end
                else
                    pend = PEND_NONE;
            end
            put(KIND_VERDICT, 8'h00, 1'b0, v, ok, l, rx_seq, tx_seq);
            rx_sum = 0;
            rx_pos = 0;
        endfunction

        function void pull();
            logic [7:0] v;
            logic       e;
            e = 1'b0;
            if (pend == PEND_REJ) begin
                if (tx_pos == 0)
                    v = {own_addr, rej_dest};
                else if (tx_pos == 1)
                    v = {tx_seq, 5'b01001};
                else if (tx_pos == 2)
                    v = 8'h00;
                else begin
                    v = tx_sum;
                    e = 1'b1;
                end
                tx_sum ^= v;
                tx_pos++;
                if (e)
                    pend = PEND_NONE;
                put(KIND_TX, v, e);
            end
            else if (pend == PEND_RETX) begin
                v = frame_mem[tx_pos];
                e = (9'(tx_pos) + 9'd1 >= 9'(frame_len));
                tx_pos++;
                if (e) begin
                    tx_seq++;
                    pend = PEND_NONE;
                end
                put(KIND_TX, v, e);
            end
        endfunction

        // predict the results of one accepted command beat
        function void note(logic [2:0] cmd, logic [7:0] b, logic last, logic [7:0] flen);
            logic [7:0] plen;
            items++;
            case (cmd)
                CMD_RX_BYTE: take_byte(b, last);
                CMD_START_I:
                    if (pend == PEND_I) begin
                        plen = (flen > MAX_PAYLOAD) ? 8'(MAX_PAYLOAD) : flen;
                        tx_pos = 0;
                        tx_sum = 0;
                        frame_len = 0;
                        frame_put({rx_addr[3:0], rx_addr[7:4]}, 1'b0);
                        frame_put({rx_seq, 1'b0, tx_seq, 1'b0}, 1'b0);
                        frame_put(plen, 1'b0);
                        if (plen == 0)
                            close_i();
                    end
                CMD_PAYLOAD:
                    if (pend == PEND_I && tx_pos >= 3) begin
                        frame_put(b, 1'b0);
                        if (9'(tx_pos) >= 9'(frame_mem[2]) + 9'd3)
                            close_i();
                    end
                CMD_PULL: pull();
                CMD_CLR_CNT:
                begin
                    rx_seq = 0;
                    tx_seq = 0;
                end
                default: ;
            endcase
        endfunction

        function void check(link_beat_t got);
            link_beat_t x;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat kind=%0d byte=%02h", got.kind, got.out_byte);
                errors++;
                return;
            end
            x = expected_q.pop_front();
            if (got.kind !== x.kind) begin
                $error("kind: expected %0d, got %0d", x.kind, got.kind); errors++;
            end
            if (got.out_byte !== x.out_byte) begin
                $error("out_byte: expected %02h, got %02h", x.out_byte, got.out_byte); errors++;
            end
            if (got.eof !== x.eof) begin
                $error("end_of_frame: expected %0d, got %0d", x.eof, got.eof); errors++;
            end
            if (got.verdict !== x.verdict) begin
                $error("verdict: expected %0d, got %0d", x.verdict, got.verdict); errors++;
            end
            if (got.ok !== x.ok) begin
                $error("checksum_ok: expected %0d, got %0d", x.ok, got.ok); errors++;
            end
            if (got.len !== x.len) begin
                $error("received_length: expected %0d, got %0d", x.len, got.len); errors++;
            end
            if (got.rc !== x.rc) begin
                $error("receive_count: expected %0d, got %0d", x.rc, got.rc); errors++;
            end
            if (got.sc !== x.sc) begin
                $error("send_count: expected %0d, got %0d", x.sc, got.sc); errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    link_scoreboard sb;
    bit  no_idle;
    int  stall_left;
    int  cycles;

    sequenced_link_block_handler dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** sequenced_link_block_handler: FAILED **");
            $finish;
        end
    end

    // result side: check each beat, then draw the stall before the next one
    always @(posedge clk)
    begin
        link_beat_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.out_byte = m_axis_tdata[7:0];
            got.eof = m_axis_tlast;
            got.verdict = m_axis_tdata[10:8];
            got.ok = m_axis_tdata[11];
            got.len = m_axis_tdata[19:12];
            got.rc = m_axis_tdata[22:20];
            got.sc = m_axis_tdata[25:23];
            sb.check(got);
            stall_left = no_idle ? 0 : $urandom_range(0, 9);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send(logic [2:0] cmd, logic [7:0] b, logic last, logic [7:0] flen);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {flen, b};
        s_axis_tuser <= cmd;
        s_axis_tlast <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note(cmd, b, last, flen);
    endtask

    // hold the sender until every expected beat has come, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_OWN_ADDR)
            sb.own_addr = val;
        else
            sb.rej_dest = val;
    endtask

    // one received block; hdr_n below 3 cuts the header short
    task automatic send_block(logic [7:0] addr, logic [7:0] ctrl, logic [7:0] len,
                              int pay_n, bit good, int hdr_n = 3);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 0;
        if (hdr_n > 0) begin send(CMD_RX_BYTE, addr, 1'b0, 8'($urandom)); sum ^= addr; end
        if (hdr_n > 1) begin send(CMD_RX_BYTE, ctrl, 1'b0, 8'($urandom)); sum ^= ctrl; end
        if (hdr_n > 2) begin
            send(CMD_RX_BYTE, len, 1'b0, 8'($urandom));
            sum ^= len;
            for (int i = 0; i < pay_n; i++) begin
                b = 8'($urandom);
                send(CMD_RX_BYTE, b, 1'b0, 8'($urandom));
                sum ^= b;
            end
        end
        send(CMD_RX_BYTE, good ? sum : sum ^ 8'(1 << $urandom_range(0, 7)), 1'b1,
             8'($urandom));
    endtask

    // serve whatever reply the last block left pending, sometimes cutting it short
    task automatic serve_reply();
        int plen;
        if (sb.pend == PEND_I) begin
            plen = ($urandom_range(0, 39) == 0) ? $urandom_range(240, 255)
                                                : $urandom_range(0, 8);
            send(CMD_START_I, 8'($urandom), 1'($urandom), 8'(plen));
            if ($urandom_range(0, 9) == 0)
                send(CMD_START_I, 8'($urandom), 1'($urandom), 8'($urandom_range(0, 5)));
            while (sb.pend == PEND_I && $urandom_range(0, 19) != 0)
                send(CMD_PAYLOAD, 8'($urandom), 1'($urandom), 8'($urandom));
        end
        else
            while ((sb.pend == PEND_REJ || sb.pend == PEND_RETX)
                   && $urandom_range(0, 14) != 0)
                send(CMD_PULL, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic random_traffic(int n_items);
        logic [7:0] ctrl;
        int         sel;
        int         stop_at;
        stop_at = sb.items + n_items;
        while (sb.items < stop_at) begin
            if ($urandom_range(0, 29) == 0)
                no_idle = !no_idle;
            sel = $urandom_range(0, 99);
            if (sel < 15)
                send(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
            else begin
                sel = $urandom_range(0, 9);
                if (sel < 5)
                    ctrl = 8'($urandom) & ~I_MASK;
                else if (sel < 8)
                    ctrl = ($urandom_range(0, 9) == 0) ? RES_CTRL
                                                       : (8'($urandom) | REJ_MASK);
                else
                    do ctrl = 8'($urandom);
                    while ((ctrl & I_MASK) == 0 || (ctrl & REJ_MASK) == REJ_MASK);
                send_block({4'($urandom),
                            ($urandom_range(0, 5) == 0) ? 4'($urandom) : sb.own_addr},
                           ctrl, 8'($urandom), $urandom_range(0, 5),
                           $urandom_range(0, 6) != 0,
                           ($urandom_range(0, 14) == 0) ? $urandom_range(0, 2) : 3);
                serve_reply();
            end
        end
    endtask

    initial
    begin
        sb = new();
        no_idle = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty retransmit, I build, retransmit, reject frame, oddities
        send_block(8'hA0, 8'h69, 8'h00, 0, 1);
        send_block(8'h50, 8'h00, 8'hFF, 2, 1);
        send(CMD_START_I, 8'h00, 1'b0, 8'd2);
        send(CMD_PAYLOAD, 8'hFF, 1'b0, 8'h00);
        send(CMD_PAYLOAD, 8'h00, 1'b0, 8'h00);
        send_block(8'h30, 8'hE9, 8'h00, 0, 1);
        repeat (6) send(CMD_PULL, 8'h00, 1'b0, 8'h00);
        send_block(8'hF0, 8'h11, 8'h00, 0, 0);
        repeat (4) send(CMD_PULL, 8'h00, 1'b0, 8'h00);
        send_block(8'h0F, 8'h00, 8'h00, 1, 1);
        send(CMD_CLR_CNT, 8'hFF, 1'b1, 8'hFF);
        send(3'd7, 8'hFF, 1'b1, 8'hFF);
        drain();

        write_reg(REG_OWN_ADDR, 4'hF);
        write_reg(REG_REJ_DEST, 4'h0);
        random_traffic(15);
        drain();

        write_reg(REG_OWN_ADDR, 4'h5);
        write_reg(REG_REJ_DEST, 4'hF);
        // long block, its position counter runs into saturation
        send_block(8'h15, 8'h00, 8'h04, 253, 1);
        random_traffic(15);
        drain();

        write_reg(REG_OWN_ADDR, 4'h0);
        write_reg(REG_REJ_DEST, 4'h3);
        random_traffic(15);
        drain();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("** sequenced_link_block_handler: PASSED **");
        else
            $display("** sequenced_link_block_handler: FAILED **");
        $finish;
    end
endmodule
